[rtl/lfu_pkg.sv]
// ---------------------------------------------------------------------------
// lfu_pkg
// Shared sizes, command codes and entry types for the LFU cache policy block.
// ---------------------------------------------------------------------------
package lfu_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W   = $clog2(ENTRIES + 1);
    localparam int CAP_W   = 5;
    localparam int CMP_W   = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int USES_W  = 32;
    localparam int STAMP_W = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [USES_W-1:0]  uses;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic key_match;
        logic empty;
        logic better;
    } t_cmp_res;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } t_state;

endpackage

[rtl/lfu_store.sv]
// ---------------------------------------------------------------------------
// lfu_store
// Entry memory: key, data, use count and stamp per slot. One write port and
// one read port with registered read data.
// ---------------------------------------------------------------------------
module lfu_store (
    input  logic                      i_clk,
    input  logic                      i_rd_en,
    input  logic [lfu_pkg::IDX_W-1:0] i_rd_addr,
    output lfu_pkg::t_entry           o_rd_entry,
    input  logic                      i_wr_en,
    input  logic [lfu_pkg::IDX_W-1:0] i_wr_addr,
    input  lfu_pkg::t_entry           i_wr_entry
);

    lfu_pkg::t_entry mem [lfu_pkg::ENTRIES];
    lfu_pkg::t_entry r_rd_entry;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry <= mem[i_rd_addr];
        end
    end

    assign o_rd_entry = r_rd_entry;

endmodule

[rtl/lfu_cmp.sv]
// ---------------------------------------------------------------------------
// lfu_cmp
// Shared compare unit: checks one scanned entry for a key match, a free slot,
// and whether it beats the current eviction candidate (count, then stamp).
// ---------------------------------------------------------------------------
module lfu_cmp (
    input  lfu_pkg::t_entry              i_entry,
    input  logic                         i_valid,
    input  logic [lfu_pkg::KEY_W-1:0]    i_key,
    input  logic                         i_best_found,
    input  logic [lfu_pkg::USES_W-1:0]   i_best_uses,
    input  logic [lfu_pkg::STAMP_W-1:0]  i_best_stamp,
    output lfu_pkg::t_cmp_res            o_res
);

    logic uses_lt;
    logic uses_eq;
    logic stamp_lt;

    assign uses_lt  = i_entry.uses < i_best_uses;
    assign uses_eq  = i_entry.uses == i_best_uses;
    assign stamp_lt = i_entry.stamp < i_best_stamp;

    always_comb begin
        o_res.key_match = i_valid && (i_entry.key == i_key);
        o_res.empty     = !i_valid;
        // strict compare keeps the lowest slot on a full tie
        o_res.better    = i_valid &&
                          (!i_best_found || uses_lt || (uses_eq && stamp_lt));
    end

endmodule

[rtl/lfu_cache_policy.sv]
// ---------------------------------------------------------------------------
// lfu_cache_policy
// Key-value store with least-frequently-used replacement, LRU tie break.
// Each request makes one pass over the entry memory through the shared compare
// unit, then writes back and registers its result in the commit state. A new
// request is taken only in idle, so it waits for the scan, the commit and the
// return to idle; a held result stalls the commit.
// Reset empties all slots (valid flops), clears the stamp counter
// and occupancy, and sets capacity to 16.
// ---------------------------------------------------------------------------
module lfu_cache_policy (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [lfu_pkg::CAP_W-1:0]  i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_command,
    input  logic [lfu_pkg::KEY_W-1:0]  i_key,
    input  logic [lfu_pkg::DATA_W-1:0] i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_hit,
    output logic [lfu_pkg::DATA_W-1:0] o_read_value
);

    localparam int IW = lfu_pkg::IDX_W;

    lfu_pkg::t_state r_state, n_state;

    logic [lfu_pkg::CAP_W-1:0]   r_cap;
    logic [lfu_pkg::ENTRIES-1:0] r_valid;
    logic [lfu_pkg::OCC_W-1:0]   r_occ;
    logic [lfu_pkg::STAMP_W-1:0] r_stamp;

    logic                        r_cmd;
    logic [lfu_pkg::KEY_W-1:0]   r_key;
    logic [lfu_pkg::DATA_W-1:0]  r_value;

    logic [IW:0]                 r_rd_idx;
    logic                        r_cmp_vld;
    logic [IW-1:0]               r_cmp_idx;

    logic                        r_hit;
    logic [IW-1:0]               r_hit_idx;
    logic [lfu_pkg::DATA_W-1:0]  r_hit_data;
    logic [lfu_pkg::USES_W-1:0]  r_hit_uses;
    logic                        r_free_found;
    logic [IW-1:0]               r_free_idx;
    logic                        r_best_found;
    logic [IW-1:0]               r_best_idx;
    logic [lfu_pkg::USES_W-1:0]  r_best_uses;
    logic [lfu_pkg::STAMP_W-1:0] r_best_stamp;

    logic                        r_out_valid;
    logic                        r_out_hit;
    logic [lfu_pkg::DATA_W-1:0]  r_out_data;

    logic                        accept;
    logic                        rd_en;
    logic                        scan_last;
    logic                        out_free;
    logic                        commit_go;
    logic                        is_put;
    logic [lfu_pkg::CMP_W-1:0]   cap_x;
    logic [lfu_pkg::CMP_W-1:0]   cap_eff;
    logic [lfu_pkg::CMP_W-1:0]   occ_x;
    logic                        do_evict;
    logic                        do_fill;
    logic                        wr_en;
    logic [IW-1:0]               wr_addr;
    lfu_pkg::t_entry             wr_entry;
    lfu_pkg::t_entry             rd_entry;
    lfu_pkg::t_cmp_res           cmp_res;
    logic [lfu_pkg::USES_W-1:0]  uses_inc;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == lfu_pkg::S_IDLE);
    assign accept      = i_in_valid && o_in_ready;

    assign rd_en     = (r_state == lfu_pkg::S_SCAN) &&
                       (r_rd_idx < (IW+1)'(lfu_pkg::ENTRIES));
    assign scan_last = r_cmp_vld && (r_cmp_idx == IW'(lfu_pkg::ENTRIES - 1));
    assign out_free  = !r_out_valid || i_out_ready;
    assign commit_go = (r_state == lfu_pkg::S_COMMIT) && out_free;

    // effective capacity is min(capacity, ENTRIES)
    assign cap_x   = lfu_pkg::CMP_W'(r_cap);
    assign cap_eff = (cap_x > lfu_pkg::CMP_W'(lfu_pkg::ENTRIES)) ?
                     lfu_pkg::CMP_W'(lfu_pkg::ENTRIES) : cap_x;
    assign occ_x   = lfu_pkg::CMP_W'(r_occ);
    assign is_put  = (r_cmd == lfu_pkg::CMD_PUT);

    assign do_evict = !r_hit && is_put && (cap_eff != '0) && (occ_x >= cap_eff) &&
                      r_best_found;
    assign do_fill  = !r_hit && is_put && (cap_eff != '0) && (occ_x < cap_eff) &&
                      r_free_found;
    assign wr_en    = commit_go && (r_hit || do_evict || do_fill);
    assign uses_inc = (r_hit_uses == '1) ? r_hit_uses : r_hit_uses + 1'b1;

    always_comb begin
        wr_entry.key   = r_key;
        wr_entry.stamp = r_stamp;
        if (r_hit) begin
            wr_addr        = r_hit_idx;
            wr_entry.data  = is_put ? r_value : r_hit_data;
            wr_entry.uses  = uses_inc;
        end else begin
            wr_addr        = do_evict ? r_best_idx : r_free_idx;
            wr_entry.data  = r_value;
            wr_entry.uses  = '0;
        end
    end

    lfu_store u_store (
        .i_clk      (i_clk),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_rd_idx[IW-1:0]),
        .o_rd_entry (rd_entry),
        .i_wr_en    (wr_en),
        .i_wr_addr  (wr_addr),
        .i_wr_entry (wr_entry)
    );

    lfu_cmp u_cmp (
        .i_entry      (rd_entry),
        .i_valid      (r_valid[r_cmp_idx]),
        .i_key        (r_key),
        .i_best_found (r_best_found),
        .i_best_uses  (r_best_uses),
        .i_best_stamp (r_best_stamp),
        .o_res        (cmp_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lfu_pkg::S_IDLE:   if (accept) n_state = lfu_pkg::S_SCAN;
            lfu_pkg::S_SCAN:   if (scan_last) n_state = lfu_pkg::S_COMMIT;
            lfu_pkg::S_COMMIT: if (out_free) n_state = lfu_pkg::S_IDLE;
            default:           n_state = lfu_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lfu_pkg::S_IDLE;
            r_cap       <= lfu_pkg::CAP_RESET;
            r_valid     <= '0;
            r_occ       <= '0;
            r_stamp     <= '0;
            r_rd_idx    <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_cfg_data;
            end
            if (accept) begin
                r_rd_idx  <= '0;
                r_cmp_vld <= 1'b0;
            end else begin
                r_cmp_vld <= rd_en;
                if (rd_en) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
            if (wr_en) begin
                r_stamp <= r_stamp + 1'b1;
            end
            // an eviction reuses its slot: valid and occupancy stay put
            if (commit_go && do_fill) begin
                r_valid[wr_addr] <= 1'b1;
                r_occ            <= r_occ + 1'b1;
            end
            if (commit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request payload and scan results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd        <= i_command;
            r_key        <= i_key;
            r_value      <= i_value;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_best_found <= 1'b0;
        end else if (r_cmp_vld) begin
            if (cmp_res.key_match && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_cmp_idx;
                r_hit_data <= rd_entry.data;
                r_hit_uses <= rd_entry.uses;
            end
            if (cmp_res.empty && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
            if (cmp_res.better) begin
                r_best_found <= 1'b1;
                r_best_idx   <= r_cmp_idx;
                r_best_uses  <= rd_entry.uses;
                r_best_stamp <= rd_entry.stamp;
            end
        end
        if (rd_en) begin
            r_cmp_idx <= r_rd_idx[IW-1:0];
        end
        if (commit_go) begin
            r_out_hit  <= r_hit;
            r_out_data <= (r_hit && !is_put) ? r_hit_data : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_data;

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ == lfu_pkg::OCC_W'($countones(r_valid)))
        else $error("occupancy out of step with valid bits");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= lfu_pkg::OCC_W'(lfu_pkg::ENTRIES))
        else $error("occupancy above depth");

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == lfu_pkg::S_SCAN) && (r_rd_idx == '0))
        else $error("request did not start a scan");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == lfu_pkg::S_COMMIT)
        else $error("result raised outside commit");

    a_stamp_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !wr_en |=> $stable(r_stamp))
        else $error("stamp moved without an entry write");

endmodule
